// ===== rtl/tts_pkg.sv =====
// shared types, constants and the sequencer control store of the totient table sieve
package tts_pkg;

    localparam int VAL_W           = 12;
    localparam int IDX_W           = 12;
    localparam int STATUS_W        = 2;
    localparam int CNT_W           = 13;
    localparam int PC_W            = 4;
    localparam int DIV_STEPS       = 12;
    localparam int DCNT_W          = 4;
    localparam int DEF_MAX_ENTRIES = 4096;
    localparam logic [CNT_W-1:0] FIRST_PRIME = CNT_W'(2);
    localparam logic [IDX_W-1:0] LIMIT_RESET = 12'hFFF;

    typedef enum logic
    {
        OP_BUILD = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_UNBUILT = 2'd2
    } status_t;

    typedef enum logic
    {
        A_N = 1'b0,
        A_P = 1'b1
    } asel_t;

    typedef enum logic
    {
        W_N    = 1'b0,
        W_PROD = 1'b1
    } wsel_t;

    typedef enum logic [1:0]
    {
        N_HOLD   = 2'd0,
        N_INC    = 2'd1,
        N_LOAD_P = 2'd2,
        N_ADD_P  = 2'd3
    } nop_t;

    typedef enum logic [2:0]
    {
        J_NONE      = 3'd0,
        J_ALWAYS    = 3'd1,
        J_N_NE_TOP  = 3'd2,
        J_P_GT_TOP  = 3'd3,
        J_NOT_PRIME = 3'd4,
        J_DIV_MORE  = 3'd5,
        J_NP_GT_TOP = 3'd6
    } jcond_t;

    // step addresses of the build program
    localparam logic [PC_W-1:0] S_INIT  = 4'd0;
    localparam logic [PC_W-1:0] S_PSET  = 4'd1;
    localparam logic [PC_W-1:0] S_PCHK  = 4'd2;
    localparam logic [PC_W-1:0] S_PRD   = 4'd3;
    localparam logic [PC_W-1:0] S_PTST  = 4'd4;
    localparam logic [PC_W-1:0] S_MRD   = 4'd5;
    localparam logic [PC_W-1:0] S_DIV0  = 4'd6;
    localparam logic [PC_W-1:0] S_DIVS  = 4'd7;
    localparam logic [PC_W-1:0] S_MUL   = 4'd8;
    localparam logic [PC_W-1:0] S_MWR   = 4'd9;
    localparam logic [PC_W-1:0] S_MLOOP = 4'd10;
    localparam logic [PC_W-1:0] S_PNXT  = 4'd11;
    localparam logic [PC_W-1:0] S_DONE  = 4'd12;

    typedef struct packed
    {
        logic            ram_en;
        logic            ram_we;
        asel_t           asel;
        wsel_t           wsel;
        nop_t            n_op;
        logic            p_init;
        logic            p_inc;
        logic            div_start;
        logic            div_step;
        logic            mul;
        logic            done;
        jcond_t          jc;
        logic [PC_W-1:0] target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '0;
        unique case (pc)
            S_INIT:
            begin
                w.ram_en = 1'b1;
                w.ram_we = 1'b1;
                w.asel   = A_N;
                w.wsel   = W_N;
                w.n_op   = N_INC;
                w.jc     = J_N_NE_TOP;
                w.target = S_INIT;
            end
            S_PSET:
            begin
                w.p_init = 1'b1;
            end
            S_PCHK:
            begin
                w.jc     = J_P_GT_TOP;
                w.target = S_DONE;
            end
            S_PRD:
            begin
                w.ram_en = 1'b1;
                w.asel   = A_P;
            end
            S_PTST:
            begin
                w.n_op   = N_LOAD_P;
                w.jc     = J_NOT_PRIME;
                w.target = S_PNXT;
            end
            S_MRD:
            begin
                w.ram_en = 1'b1;
                w.asel   = A_N;
            end
            S_DIV0:
            begin
                w.div_start = 1'b1;
            end
            S_DIVS:
            begin
                w.div_step = 1'b1;
                w.jc       = J_DIV_MORE;
                w.target   = S_DIVS;
            end
            S_MUL:
            begin
                w.mul = 1'b1;
            end
            S_MWR:
            begin
                w.ram_en = 1'b1;
                w.ram_we = 1'b1;
                w.asel   = A_N;
                w.wsel   = W_PROD;
                w.n_op   = N_ADD_P;
                w.jc     = J_NP_GT_TOP;
                w.target = S_PNXT;
            end
            S_MLOOP:
            begin
                w.jc     = J_ALWAYS;
                w.target = S_MRD;
            end
            S_PNXT:
            begin
                w.p_inc  = 1'b1;
                w.jc     = J_ALWAYS;
                w.target = S_PCHK;
            end
            default:
            begin
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/totient_table_sieve.sv =====
// top level of the totient table sieve: microcoded build sequencer and read path
//
// usage
//   input channel (in_valid/in_ready) carries one request: operation and index.
//   a build request fills the table for 0..limit by the sieve and answers with
//   value zero, status ok. a read request answers with phi(index), or status
//   "not built" (checked first) or "index above limit" with value zero.
//   the output channel (out_valid/out_ready) carries one answer per request.
//   limit is set over the APB port at any address; writing it drops the built flag.
// timing
//   a read answer passes the pending stage behind the registered memory read
//   and then the output register; a new request is taken only once the
//   pending stage is empty. a build runs the divide loop (12 steps) for
//   every multiple of each prime, and that loop dominates its length.
// reset
//   clears the built flag, sets limit to 4095; table contents are undefined.
// stall
//   an answer waits in the output register while the next request is taken;
//   a further answer waits in a pending stage and blocks new requests.
module totient_table_sieve #(
    parameter int MAX_ENTRIES = tts_pkg::DEF_MAX_ENTRIES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                operation,
    input  logic [tts_pkg::IDX_W-1:0]           index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tts_pkg::VAL_W-1:0]           totient_value,
    output logic [tts_pkg::STATUS_W-1:0]        status,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [1:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    import tts_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam logic [IDX_W-1:0] TOP_CAP =
        (MAX_ENTRIES - 1 > 4095) ? 12'hFFF : IDX_W'(MAX_ENTRIES - 1);

    // control state
    logic                 busy_reg, busy_next;
    logic [PC_W-1:0]      pc_reg, pc_next;
    logic                 built_reg, built_next;
    logic                 pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]     limit_reg, limit_next;

    // datapath
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]     p_reg, p_next;
    logic [VAL_W-1:0]     rem_reg, rem_next;
    logic [VAL_W-1:0]     quo_reg, quo_next;
    logic [DCNT_W-1:0]    dcnt_reg, dcnt_next;
    logic [VAL_W-1:0]     prod_reg, prod_next;
    status_t              pend_status_reg, pend_status_next;
    logic                 pend_ram_reg, pend_ram_next;
    logic [VAL_W-1:0]     value_reg, value_next;
    status_t              status_reg, status_next;

    ucode_t               uc;
    logic                 jump;
    logic [IDX_W-1:0]     top;
    logic                 in_acc;
    logic                 rd_acc;
    logic                 cfg_wr;
    logic                 out_load;
    logic [CNT_W:0]       np_sum;
    logic [VAL_W:0]       shifted;
    logic [VAL_W+1:0]     diff;
    logic [2*VAL_W-1:0]   prod_full;
    logic [VAL_W-1:0]     p_low;

    logic                 ram_en;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [VAL_W-1:0]     ram_wdata;
    logic [VAL_W-1:0]     ram_rdata;

    assign top      = (limit_reg > TOP_CAP) ? TOP_CAP : limit_reg;
    assign in_ready = !busy_reg && !pend_reg;
    assign in_acc   = in_valid && in_ready;
    assign rd_acc   = in_acc && (operation == OP_READ);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_load = pend_reg && (!out_valid_reg || out_ready);
    assign uc       = busy_reg ? ucode_rom(pc_reg) : '0;
    assign p_low    = p_reg[VAL_W-1:0];
    assign np_sum   = {1'b0, n_reg} + {1'b0, p_reg};

    // one restoring divide step: exact division of the entry by the prime
    assign shifted   = {rem_reg, quo_reg[VAL_W-1]};
    assign diff      = {1'b0, shifted} - {2'b00, p_low};
    assign prod_full = quo_reg * (p_low - VAL_W'(1));

    always_comb
    begin
        case (uc.jc)
            J_ALWAYS:    jump = 1'b1;
            J_N_NE_TOP:  jump = (n_reg != {1'b0, top});
            J_P_GT_TOP:  jump = (p_reg > {1'b0, top});
            J_NOT_PRIME: jump = ({1'b0, ram_rdata} != p_reg);
            J_DIV_MORE:  jump = (dcnt_reg != DCNT_W'(DIV_STEPS - 1));
            J_NP_GT_TOP: jump = (np_sum > {2'b00, top});
            default:     jump = 1'b0;
        endcase
    end

    // memory port
    always_comb
    begin
        ram_en    = uc.ram_en || rd_acc;
        ram_we    = uc.ram_we;
        ram_wdata = (uc.wsel == W_PROD) ? prod_reg : n_reg[VAL_W-1:0];
        if (!busy_reg)
        begin
            ram_addr = ADDR_W'(index);
        end
        else if (uc.asel == A_P)
        begin
            ram_addr = ADDR_W'(p_low);
        end
        else
        begin
            ram_addr = ADDR_W'(n_reg[VAL_W-1:0]);
        end
    end

    tts_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // control next state
    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        built_next     = built_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        limit_next     = limit_reg;

        if (busy_reg)
        begin
            pc_next = jump ? uc.target : pc_reg + PC_W'(1);
            if (uc.done)
            begin
                busy_next  = 1'b0;
                built_next = 1'b1;
                pend_next  = 1'b1;
            end
        end

        if (in_acc)
        begin
            if (operation == OP_BUILD)
            begin
                busy_next = 1'b1;
                pc_next   = S_INIT;
            end
            else
            begin
                pend_next = 1'b1;
            end
        end

        if (out_load)
        begin
            pend_next      = 1'b0;
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_wr)
        begin
            limit_next = pwdata[IDX_W-1:0];
            built_next = 1'b0;
        end
    end

    // datapath next state
    always_comb
    begin
        n_next           = n_reg;
        p_next           = p_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        dcnt_next        = dcnt_reg;
        prod_next        = prod_reg;
        pend_status_next = pend_status_reg;
        pend_ram_next    = pend_ram_reg;
        value_next       = value_reg;
        status_next      = status_reg;

        case (uc.n_op)
            N_INC:    n_next = n_reg + CNT_W'(1);
            N_LOAD_P: n_next = p_reg;
            N_ADD_P:  n_next = np_sum[CNT_W-1:0];
            default:  n_next = n_reg;
        endcase

        if (uc.p_init)
        begin
            p_next = FIRST_PRIME;
        end
        else if (uc.p_inc)
        begin
            p_next = p_reg + CNT_W'(1);
        end

        if (uc.div_start)
        begin
            rem_next  = '0;
            quo_next  = ram_rdata;
            dcnt_next = '0;
        end
        else if (uc.div_step)
        begin
            dcnt_next = dcnt_reg + DCNT_W'(1);
            if (!diff[VAL_W+1])
            begin
                rem_next = diff[VAL_W-1:0];
                quo_next = {quo_reg[VAL_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[VAL_W-1:0];
                quo_next = {quo_reg[VAL_W-2:0], 1'b0};
            end
        end

        if (uc.mul)
        begin
            prod_next = prod_full[VAL_W-1:0];
        end

        if (uc.done)
        begin
            pend_status_next = ST_OK;
            pend_ram_next    = 1'b0;
        end

        if (in_acc)
        begin
            n_next = '0;
            if (operation == OP_READ)
            begin
                pend_ram_next = 1'b0;
                if (!built_reg)
                begin
                    pend_status_next = ST_UNBUILT;
                end
                else if (index > top)
                begin
                    pend_status_next = ST_RANGE;
                end
                else
                begin
                    pend_status_next = ST_OK;
                    pend_ram_next    = 1'b1;
                end
            end
        end

        if (out_load)
        begin
            value_next  = pend_ram_reg ? ram_rdata : '0;
            status_next = pend_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= S_INIT;
            built_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            built_reg     <= built_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            limit_reg     <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg           <= n_next;
        p_reg           <= p_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        dcnt_reg        <= dcnt_next;
        prod_reg        <= prod_next;
        pend_status_reg <= pend_status_next;
        pend_ram_reg    <= pend_ram_next;
        value_reg       <= value_next;
        status_reg      <= status_next;
    end

    assign out_valid     = out_valid_reg;
    assign totient_value = value_reg;
    assign status        = status_reg;
    assign prdata        = {{(32 - IDX_W){1'b0}}, limit_reg};
    assign pready        = 1'b1;

    // a pending answer and a running build never coexist
    assert property (@(posedge clk) disable iff (!rst_n) !(busy_reg && pend_reg))
        else $error("pending answer while build runs");

    // an accepted build starts the program at its first step
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && operation == OP_BUILD) |=> (busy_reg && pc_reg == S_INIT))
        else $error("build request did not start the sequencer");

    // the table is only written by the build program
    assert property (@(posedge clk) disable iff (!rst_n) ram_we |-> busy_reg)
        else $error("table write outside a build");

    // the built flag only comes up together with the build answer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(built_reg) |-> (pend_reg && !busy_reg))
        else $error("built flag set without build answer");

endmodule

// ===== rtl/tts_ram.sv =====
// single-port RAM with registered read data
module tts_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule
